/* hw/rtl/dag_longest_path_top_defines.svh */
// Assertion macros for the top level of the longest-path block.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef DAG_LONGEST_PATH_TOP_DEFINES_SVH
`define DAG_LONGEST_PATH_TOP_DEFINES_SVH

// same-cycle implication
`define DLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// next-cycle implication
`define DLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

/* hw/rtl/dlp_pkg.sv */
// Shared types and constants of the longest-path block.
// No dependencies.
package dlp_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);

  // field widths fixed by the interface
  localparam int NODE_W = 10;
  localparam int CFG_W  = 11;
  localparam int RES_W  = 11;

  typedef struct packed {
    logic [NODE_W-1:0] edge_parent;
    logic [NODE_W-1:0] edge_child;
    logic              has_edge;
    logic              last_item;
  } dlp_in_t;

  typedef struct packed {
    logic [RES_W-1:0] source_count;
    logic [RES_W-1:0] path_nodes;
    logic             edge_overflow;
  } dlp_out_t;

  // one node word: in-degree, CSR fill pointer / end, CSR start, path length
  typedef struct packed {
    logic [ECNT_W-1:0] indeg;
    logic [ECNT_W-1:0] fill;
    logic [ECNT_W-1:0] start;
    logic [NCNT_W-1:0] plen;
  } dlp_node_t;

  typedef struct packed {
    logic               we;
    logic [EDGE_AW-1:0] addr;
    logic [NODE_AW-1:0] src_node;
    logic [NODE_AW-1:0] dst_node;
  } dlp_load_t;

  typedef struct packed {
    logic              done;
    logic [NCNT_W-1:0] sources;
    logic [NCNT_W-1:0] longest;
  } dlp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_CNT,
    ST_PFX,
    ST_SCT,
    ST_POP,
    ST_EDGE,
    ST_DONE
  } dlp_state_t;

  typedef enum logic [2:0] {
    PH_ISSUE,
    PH_LATCH,
    PH_WR_A,
    PH_RD_B,
    PH_WR_B
  } dlp_phase_t;

endpackage

/* hw/rtl/dlp_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/dlp_engine.sv */
// Sequencer and memories: edge store, node words, CSR adjacency, ready queue.
// Depends on dlp_pkg and dlp_ram.
module dlp_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dlp_pkg::dlp_load_t         ld,
  input  logic                       start,
  input  logic [dlp_pkg::NCNT_W-1:0] n,
  input  logic [dlp_pkg::ECNT_W-1:0] total,
  input  logic                       ack,
  output dlp_pkg::dlp_res_t          res
);

  localparam int NODE_AW = dlp_pkg::NODE_AW;
  localparam int EDGE_AW = dlp_pkg::EDGE_AW;
  localparam int NCNT_W  = dlp_pkg::NCNT_W;
  localparam int ECNT_W  = dlp_pkg::ECNT_W;
  localparam int EW_W    = 2 * NODE_AW;

  dlp_pkg::dlp_state_t state_r, state_nxt;
  dlp_pkg::dlp_phase_t ph_r, ph_nxt;

  logic [ECNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ECNT_W-1:0]  sum_r, sum_nxt;
  logic [ECNT_W-1:0]  k_r, k_nxt;
  logic [ECNT_W-1:0]  kend_r, kend_nxt;
  logic [NCNT_W-1:0]  head_r, head_nxt;
  logic [NCNT_W-1:0]  tail_r, tail_nxt;
  logic [NCNT_W-1:0]  src_r, src_nxt;
  logic [NCNT_W-1:0]  best_r, best_nxt;
  logic [NCNT_W-1:0]  du_r, du_nxt;
  logic [NODE_AW-1:0] es_r, es_nxt;
  logic [NODE_AW-1:0] ed_r, ed_nxt;
  logic [NODE_AW-1:0] b_r, b_nxt;

  // memory ports
  logic [EW_W-1:0]    e_rd;
  logic [EDGE_AW-1:0] e_raddr;
  logic               n_we;
  logic [NODE_AW-1:0] n_waddr, n_raddr;
  dlp_pkg::dlp_node_t n_wdata, n_rd;
  logic               a_we;
  logic [EDGE_AW-1:0] a_waddr, a_raddr;
  logic [NODE_AW-1:0] a_wdata, a_rd;
  logic               q_we;
  logic [NODE_AW-1:0] q_waddr, q_raddr, q_wdata, q_rd;

  logic [NODE_AW-1:0] e_src, e_dst;
  logic               e_ok;
  logic [ECNT_W-1:0]  n_e;
  logic [NCNT_W-1:0]  du_inc;

  assign e_src  = e_rd[EW_W-1:NODE_AW];
  assign e_dst  = e_rd[NODE_AW-1:0];
  assign e_ok   = (NCNT_W'(e_src) < n) && (NCNT_W'(e_dst) < n);
  assign n_e    = ECNT_W'(n);
  assign du_inc = du_r + NCNT_W'(1);

  dlp_ram #(.WIDTH(EW_W), .DEPTH(dlp_pkg::MAX_EDGES)) u_edge_mem (
    .clk   (clk),
    .we    (ld.we),
    .waddr (ld.addr),
    .wdata ({ld.src_node, ld.dst_node}),
    .raddr (e_raddr),
    .rdata (e_rd)
  );

  dlp_ram #(.WIDTH($bits(dlp_pkg::dlp_node_t)), .DEPTH(dlp_pkg::MAX_NODES)) u_node_mem (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rd)
  );

  dlp_ram #(.WIDTH(NODE_AW), .DEPTH(dlp_pkg::MAX_EDGES)) u_adj_mem (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  dlp_ram #(.WIDTH(NODE_AW), .DEPTH(dlp_pkg::MAX_NODES)) u_queue_mem (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlp_pkg::ST_IDLE;
      ph_r    <= dlp_pkg::PH_ISSUE;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    k_r    <= k_nxt;
    kend_r <= kend_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    src_r  <= src_nxt;
    best_r <= best_nxt;
    du_r   <= du_nxt;
    es_r   <= es_nxt;
    ed_r   <= ed_nxt;
    b_r    <= b_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    k_nxt     = k_r;
    kend_nxt  = kend_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    src_nxt   = src_r;
    best_nxt  = best_r;
    du_nxt    = du_r;
    es_nxt    = es_r;
    ed_nxt    = ed_r;
    b_nxt     = b_r;

    e_raddr = cnt_r[EDGE_AW-1:0];
    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = n_rd;
    n_raddr = '0;
    a_we    = 1'b0;
    a_waddr = n_rd.fill[EDGE_AW-1:0];
    a_wdata = ed_r;
    a_raddr = k_r[EDGE_AW-1:0];
    q_we    = 1'b0;
    q_waddr = tail_r[NODE_AW-1:0];
    q_wdata = '0;
    q_raddr = head_r[NODE_AW-1:0];

    res.done    = 1'b0;
    res.sources = src_r;
    res.longest = best_r;

    unique case (state_r)
      dlp_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = dlp_pkg::ST_CLR;
          cnt_nxt   = '0;
        end
      end

      dlp_pkg::ST_CLR: begin
        if (cnt_r >= n_e) begin
          state_nxt = dlp_pkg::ST_CNT;
          ph_nxt    = dlp_pkg::PH_ISSUE;
          cnt_nxt   = '0;
        end else begin
          n_we    = 1'b1;
          n_waddr = cnt_r[NODE_AW-1:0];
          n_wdata = '0;
          cnt_nxt = cnt_r + ECNT_W'(1);
        end
      end

      // in-degree and out-degree count; the two RMWs run back to back
      dlp_pkg::ST_CNT: begin
        unique case (ph_r)
          dlp_pkg::PH_ISSUE: begin
            if (cnt_r >= total) begin
              state_nxt = dlp_pkg::ST_PFX;
              cnt_nxt   = '0;
              sum_nxt   = '0;
              src_nxt   = '0;
              tail_nxt  = '0;
            end else begin
              ph_nxt = dlp_pkg::PH_LATCH;
            end
          end
          dlp_pkg::PH_LATCH: begin
            es_nxt = e_src;
            ed_nxt = e_dst;
            if (e_ok) begin
              n_raddr = e_dst;
              ph_nxt  = dlp_pkg::PH_WR_A;
            end else begin
              cnt_nxt = cnt_r + ECNT_W'(1);
              ph_nxt  = dlp_pkg::PH_ISSUE;
            end
          end
          dlp_pkg::PH_WR_A: begin
            n_we          = 1'b1;
            n_waddr       = ed_r;
            n_wdata.indeg = n_rd.indeg + ECNT_W'(1);
            ph_nxt        = dlp_pkg::PH_RD_B;
          end
          dlp_pkg::PH_RD_B: begin
            n_raddr = es_r;
            ph_nxt  = dlp_pkg::PH_WR_B;
          end
          dlp_pkg::PH_WR_B: begin
            n_we         = 1'b1;
            n_waddr      = es_r;
            n_wdata.fill = n_rd.fill + ECNT_W'(1);
            cnt_nxt      = cnt_r + ECNT_W'(1);
            ph_nxt       = dlp_pkg::PH_ISSUE;
          end
          default: ph_nxt = dlp_pkg::PH_ISSUE;
        endcase
      end

      // prefix sum of out-degrees into CSR starts, seed the ready queue
      dlp_pkg::ST_PFX: begin
        unique case (ph_r)
          dlp_pkg::PH_ISSUE: begin
            if (cnt_r >= n_e) begin
              state_nxt = dlp_pkg::ST_SCT;
              cnt_nxt   = '0;
            end else begin
              n_raddr = cnt_r[NODE_AW-1:0];
              ph_nxt  = dlp_pkg::PH_LATCH;
            end
          end
          dlp_pkg::PH_LATCH: begin
            n_we          = 1'b1;
            n_waddr       = cnt_r[NODE_AW-1:0];
            n_wdata.fill  = sum_r;
            n_wdata.start = sum_r;
            n_wdata.plen  = (n_rd.indeg == '0) ? NCNT_W'(1) : '0;
            sum_nxt       = sum_r + n_rd.fill;
            if (n_rd.indeg == '0) begin
              q_we     = 1'b1;
              q_wdata  = cnt_r[NODE_AW-1:0];
              tail_nxt = tail_r + NCNT_W'(1);
              src_nxt  = src_r + NCNT_W'(1);
            end
            cnt_nxt = cnt_r + ECNT_W'(1);
            ph_nxt  = dlp_pkg::PH_ISSUE;
          end
          default: ph_nxt = dlp_pkg::PH_ISSUE;
        endcase
      end

      // scatter children into the adjacency store
      dlp_pkg::ST_SCT: begin
        unique case (ph_r)
          dlp_pkg::PH_ISSUE: begin
            if (cnt_r >= total) begin
              state_nxt = dlp_pkg::ST_POP;
              head_nxt  = '0;
              best_nxt  = '0;
            end else begin
              ph_nxt = dlp_pkg::PH_LATCH;
            end
          end
          dlp_pkg::PH_LATCH: begin
            es_nxt = e_src;
            ed_nxt = e_dst;
            if (e_ok) begin
              n_raddr = e_src;
              ph_nxt  = dlp_pkg::PH_WR_A;
            end else begin
              cnt_nxt = cnt_r + ECNT_W'(1);
              ph_nxt  = dlp_pkg::PH_ISSUE;
            end
          end
          dlp_pkg::PH_WR_A: begin
            a_we         = 1'b1;
            n_we         = 1'b1;
            n_waddr      = es_r;
            n_wdata.fill = n_rd.fill + ECNT_W'(1);
            cnt_nxt      = cnt_r + ECNT_W'(1);
            ph_nxt       = dlp_pkg::PH_ISSUE;
          end
          default: ph_nxt = dlp_pkg::PH_ISSUE;
        endcase
      end

      dlp_pkg::ST_POP: begin
        unique case (ph_r)
          dlp_pkg::PH_ISSUE: begin
            if (head_r >= tail_r) begin
              state_nxt = dlp_pkg::ST_DONE;
            end else begin
              head_nxt = head_r + NCNT_W'(1);
              ph_nxt   = dlp_pkg::PH_LATCH;
            end
          end
          dlp_pkg::PH_LATCH: begin
            n_raddr = q_rd;
            ph_nxt  = dlp_pkg::PH_WR_A;
          end
          dlp_pkg::PH_WR_A: begin
            du_nxt   = n_rd.plen;
            k_nxt    = n_rd.start;
            kend_nxt = n_rd.fill;
            // sources never count toward the longest path
            if (head_r > src_r && n_rd.plen > best_r) begin
              best_nxt = n_rd.plen;
            end
            state_nxt = dlp_pkg::ST_EDGE;
            ph_nxt    = dlp_pkg::PH_ISSUE;
          end
          default: ph_nxt = dlp_pkg::PH_ISSUE;
        endcase
      end

      // relax each out-edge of the popped node
      dlp_pkg::ST_EDGE: begin
        unique case (ph_r)
          dlp_pkg::PH_ISSUE: begin
            if (k_r >= kend_r) begin
              state_nxt = dlp_pkg::ST_POP;
            end else begin
              k_nxt  = k_r + ECNT_W'(1);
              ph_nxt = dlp_pkg::PH_LATCH;
            end
          end
          dlp_pkg::PH_LATCH: begin
            b_nxt   = a_rd;
            n_raddr = a_rd;
            ph_nxt  = dlp_pkg::PH_WR_A;
          end
          dlp_pkg::PH_WR_A: begin
            n_we    = 1'b1;
            n_waddr = b_r;
            if (du_inc > n_rd.plen) begin
              n_wdata.plen = du_inc;
            end
            if (n_rd.indeg != '0) begin
              n_wdata.indeg = n_rd.indeg - ECNT_W'(1);
              if (n_rd.indeg == ECNT_W'(1) && tail_r < n) begin
                q_we     = 1'b1;
                q_wdata  = b_r;
                tail_nxt = tail_r + NCNT_W'(1);
              end
            end
            ph_nxt = dlp_pkg::PH_ISSUE;
          end
          default: ph_nxt = dlp_pkg::PH_ISSUE;
        endcase
      end

      dlp_pkg::ST_DONE: begin
        res.done = 1'b1;
        if (ack) begin
          state_nxt = dlp_pkg::ST_IDLE;
        end
      end

      default: state_nxt = dlp_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/dag_longest_path_top.sv */
// Top level of the longest-path block: config register, edge loading, result register.
// Depends on dlp_pkg, dlp_engine and dag_longest_path_top_defines.svh.
//
// Usage: set node_count through cfg_we/cfg_wdata while idle (reset value 1,
// saturates at 1024). Send edges as requests on in_valid/in_ready, one per
// cycle while in_ready is high; edges with an endpoint >= node_count are
// ignored, edges past 4096 are dropped and set edge_overflow. The request
// with last_item set (it may carry an edge too) starts the computation;
// in_ready stays low until its result has been moved into the output register.
// The computation runs in passes over the edges and the nodes. Every pass
// is one access per cycle to a single-port-read node memory: a clear pass
// over the nodes, a degree count pass over the edges, a prefix pass, a
// scatter pass, and a pop of each node from the ready queue that relaxes
// each of its out-edges.
// One result is presented on out_valid/out_data and held until out_ready;
// a stalled result holds back only the next result, not edge loading.
// Reset (rst_n low, synchronous) empties the edge store, clears overflow and
// any pending result, and returns node_count to 1.
`include "dag_longest_path_top_defines.svh"

module dag_longest_path_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  dlp_pkg::dlp_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dlp_pkg::dlp_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [dlp_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int NCNT_W = dlp_pkg::NCNT_W;
  localparam int ECNT_W = dlp_pkg::ECNT_W;

  logic [dlp_pkg::CFG_W-1:0] cfg_r;
  logic [ECNT_W-1:0]         total_r, total_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      busy_r, busy_nxt;
  logic                      start_r, start_nxt;
  logic                      out_valid_r, out_valid_nxt;
  dlp_pkg::dlp_out_t         out_r, out_nxt;

  logic [NCNT_W-1:0] n;
  logic              acc;
  logic              edge_ok;
  logic              ack;
  dlp_pkg::dlp_load_t ld;
  dlp_pkg::dlp_res_t  res;

  assign n = (cfg_r > dlp_pkg::CFG_W'(dlp_pkg::MAX_NODES)) ?
             NCNT_W'(dlp_pkg::MAX_NODES) : NCNT_W'(cfg_r);

  assign in_ready  = !busy_r;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign ack       = res.done && (!out_valid_r || out_ready);

  assign edge_ok = acc && in_data.has_edge &&
                   (NCNT_W'(in_data.edge_parent) < n) &&
                   (NCNT_W'(in_data.edge_child) < n);

  assign ld.we       = edge_ok && (total_r < ECNT_W'(dlp_pkg::MAX_EDGES));
  assign ld.addr     = total_r[dlp_pkg::EDGE_AW-1:0];
  assign ld.src_node = in_data.edge_parent;
  assign ld.dst_node = in_data.edge_child;

  dlp_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (ld),
    .start (start_r),
    .n     (n),
    .total (total_r),
    .ack   (ack),
    .res   (res)
  );

  always_comb begin
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (ld.we) begin
      total_nxt = total_r + ECNT_W'(1);
    end else if (edge_ok) begin
      ovf_nxt = 1'b1;
    end
    if (acc && in_data.last_item) begin
      busy_nxt  = 1'b1;
      start_nxt = 1'b1;
    end

    if (ack) begin
      out_valid_nxt         = 1'b1;
      out_nxt.source_count  = res.sources;
      out_nxt.path_nodes    = res.longest;
      out_nxt.edge_overflow = ovf_r;
      total_nxt             = '0;
      ovf_nxt               = 1'b0;
      busy_nxt              = 1'b0;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= dlp_pkg::CFG_W'(1);
      total_r     <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  `DLP_ASSERT_NEXT(a_last_sets_busy, acc && in_data.last_item, busy_r && start_r)
  `DLP_ASSERT_NOW(a_done_only_busy, res.done, busy_r)
  `DLP_ASSERT_NOW(a_total_bounded, 1'b1, total_r <= ECNT_W'(dlp_pkg::MAX_EDGES))
  `DLP_ASSERT_NEXT(a_ack_clears, ack, !busy_r && out_valid_r && total_r == '0)

endmodule

/* test/dag_longest_path_top_test.sv */
// Testbench for dag_longest_path_top: queued edge requests, a scoreboard of predicted results.
// Depends on dlp_pkg and the RTL of dag_longest_path_top.
`timescale 1ns / 100ps

module dag_longest_path_top_test;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int MAX_NODES   = dlp_pkg::MAX_NODES;
  localparam int MAX_EDGES   = dlp_pkg::MAX_EDGES;
  localparam int CFG_W       = dlp_pkg::CFG_W;
  localparam int NODE_W      = dlp_pkg::NODE_W;
  localparam int RES_W       = dlp_pkg::RES_W;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  dlp_pkg::dlp_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  dlp_pkg::dlp_out_t out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  dag_longest_path_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dlp_pkg::dlp_in_t  edge_reqs[$];
  dlp_pkg::dlp_out_t graph_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit in_taken = 1'b0;
  bit long_hold_req = 1'b0;
  bit long_hold_used = 1'b0;
  int unsigned long_hold_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned items_queued = 0;

  // predictor state
  logic [CFG_W-1:0] node_cfg = 11'd1;
  logic [NODE_W-1:0] stored_from[MAX_EDGES];
  logic [NODE_W-1:0] stored_to[MAX_EDGES];
  int unsigned stored_edges = 0;
  bit dropped_edges = 1'b0;
  int unsigned indeg[MAX_NODES];
  int unsigned path_len[MAX_NODES];
  int unsigned ready_nodes[MAX_NODES];

  function automatic int unsigned active_nodes();
    return (node_cfg > MAX_NODES) ? MAX_NODES : node_cfg;
  endfunction

  // Kahn sort over the stored edges; returns one result per graph
  function automatic dlp_pkg::dlp_out_t kahn_predict();
    dlp_pkg::dlp_out_t r;
    int unsigned n, head, tail, srcs, best, u, b;
    n = active_nodes();
    head = 0; tail = 0; srcs = 0; best = 0;
    for (int i = 0; i < n; i++) begin
      indeg[i] = 0;
      path_len[i] = 0;
    end
    for (int e = 0; e < stored_edges; e++)
      if (stored_from[e] < n && stored_to[e] < n) indeg[stored_to[e]]++;
    for (int i = 0; i < n; i++)
      if (indeg[i] == 0) begin
        ready_nodes[tail++] = i;
        path_len[i] = 1;
        srcs++;
      end
    while (head < tail) begin
      u = ready_nodes[head++];
      // only nodes popped after the sources may set the longest path
      if (path_len[u] > best && indeg[u] == 0 && head > srcs) best = path_len[u];
      for (int e = 0; e < stored_edges; e++) begin
        b = stored_to[e];
        if (stored_from[e] != u || b >= n) continue;
        if (path_len[u] + 1 > path_len[b]) path_len[b] = path_len[u] + 1;
        if (indeg[b] > 0) begin
          indeg[b]--;
          if (indeg[b] == 0 && tail < n) ready_nodes[tail++] = b;
        end
      end
    end
    r.source_count = srcs[RES_W-1:0];
    r.path_nodes = best[RES_W-1:0];
    r.edge_overflow = dropped_edges;
    return r;
  endfunction

  function automatic bit accept_edge_req(input dlp_pkg::dlp_in_t req,
                                         output dlp_pkg::dlp_out_t res);
    int unsigned n;
    n = active_nodes();
    res = '0;
    if (req.has_edge && req.edge_parent < n && req.edge_child < n) begin
      if (stored_edges < MAX_EDGES) begin
        stored_from[stored_edges] = req.edge_parent;
        stored_to[stored_edges] = req.edge_child;
        stored_edges++;
      end else begin
        dropped_edges = 1'b1;
      end
    end
    if (!req.last_item) return 1'b0;
    res = kahn_predict();
    stored_edges = 0;
    dropped_edges = 1'b0;
    return 1'b1;
  endfunction

  // scoreboard: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    dlp_pkg::dlp_out_t want;
    bit emits;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("dag_longest_path_top_test: errors");
      $finish;
    end
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        emits = accept_edge_req(in_data, want);
        if (emits) graph_results.insert(graph_results.size(), want);
      end
      if (cfg_we) node_cfg = cfg_wdata;
      if (out_valid && out_ready) begin
        if (graph_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result src=%0d path=%0d ovf=%0b", $time,
                   out_data.source_count, out_data.path_nodes, out_data.edge_overflow);
        end else begin
          want = graph_results.pop_front();
          results_checked++;
          if (out_data.source_count !== want.source_count ||
              out_data.path_nodes !== want.path_nodes ||
              out_data.edge_overflow !== want.edge_overflow) begin
            errors++;
            $display("%0t: mismatch expected src=%0d path=%0d ovf=%0b got src=%0d path=%0d ovf=%0b",
                     $time, want.source_count, want.path_nodes, want.edge_overflow,
                     out_data.source_count, out_data.path_nodes, out_data.edge_overflow);
          end
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the offered request
    end else if (edge_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_data <= edge_reqs.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // long receiver hold-off, counted here
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_used) begin
      long_hold_left <= 20000;
      long_hold_used <= 1'b1;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && long_hold_left == 0 && !(long_hold_req && !long_hold_used) &&
                 $urandom_range(99) >= recv_stall_pct;
  end

  task automatic push_req(input int unsigned p, input int unsigned c, input bit e, input bit l);
    dlp_pkg::dlp_in_t r;
    r.edge_parent = p[NODE_W-1:0];
    r.edge_child = c[NODE_W-1:0];
    r.has_edge = e;
    r.last_item = l;
    edge_reqs.insert(edge_reqs.size(), r);
    items_queued++;
  endtask

  task automatic write_node_count(input int unsigned v);
    @(negedge clk);
    cfg_wdata <= v[CFG_W-1:0];
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request is sent and every result has come, then let the block settle
  task automatic drain();
    do @(posedge clk);
    while (edge_reqs.size() != 0 || in_valid || graph_results.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  // one random graph, mostly forward edges with cycles, strays and blanks mixed in
  task automatic random_graph(input int unsigned n, input int unsigned edges);
    int unsigned p, c, kind, top;
    top = (n == 0) ? 0 : ((n > MAX_NODES) ? MAX_NODES - 1 : n - 1);
    for (int i = 0; i <= edges; i++) begin
      kind = $urandom_range(99);
      p = $urandom_range(top);
      c = $urandom_range(top);
      if (kind < 65) begin
        if (p > c) begin p = p ^ c; c = p ^ c; p = p ^ c; end
        if (p == c && c < top) c++;
      end else if (kind < 85) begin
        // keep the random pair, cycles and self loops allowed
      end else if (kind < 95) begin
        if ($urandom_range(1)) p = $urandom_range(1023); else c = $urandom_range(1023);
      end
      if (i == edges) push_req(p, c, kind < 95 && $urandom_range(1), 1'b1);
      else push_req(p, c, kind < 95, 1'b0);
    end
  endtask

  int unsigned n_pick, graphs;

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset value of one node, no edges
    push_req(0, 0, 1'b0, 1'b1);
    drain();
    write_node_count(0);
    push_req(0, 0, 1'b1, 1'b1);
    drain();
    write_node_count(4);
    push_req(0, 1, 1'b1, 1'b0);
    push_req(1, 2, 1'b1, 1'b0);
    push_req(1, 2, 1'b1, 1'b0);   // duplicate
    push_req(9, 1, 1'b1, 1'b0);   // endpoint out of range
    push_req(2, 3, 1'b1, 1'b1);
    push_req(2, 2, 1'b1, 1'b0);   // self loop
    push_req(0, 3, 1'b1, 1'b1);
    push_req(1, 2, 1'b1, 1'b0);   // cycle between 1, 2 and 3
    push_req(2, 3, 1'b1, 1'b0);
    push_req(3, 1, 1'b1, 1'b0);
    push_req(0, 1, 1'b1, 1'b1);
    drain();
    write_node_count(2047);       // saturates at the full node range
    push_req(0, 1023, 1'b1, 1'b0);
    push_req(1023, 512, 1'b1, 1'b0);
    push_req(1023, 1023, 1'b0, 1'b0);
    push_req(512, 1, 1'b1, 1'b1);
    drain();
    write_node_count(1024);
    push_req(1023, 0, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        3: begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; long_hold_req = 1'b1; end
      endcase
      graphs = 0;
      while (items_queued < 18 + (ph + 1) * 360) begin
        case ($urandom_range(19))
          0: n_pick = 0;
          1: n_pick = 1024 + $urandom_range(1023);
          2: n_pick = $urandom_range(600, 1024);
          default: n_pick = $urandom_range(1, 16);
        endcase
        write_node_count(n_pick);
        for (int g = 0; g < 4; g++) begin
          random_graph(n_pick, (n_pick > 64) ? $urandom_range(40) : $urandom_range(24));
          graphs++;
        end
        drain();
      end
    end

    $display("checked %0d graph results over %0d requests", results_checked, items_queued);
    $display("node counts from 0 to 2047, idle and stall mixes, one long result hold-off");
    if (errors == 0) begin
      $display("dag_longest_path_top_test: clean");
    end else begin
      $display("dag_longest_path_top_test: errors");
    end
    $finish;
  end

endmodule
